### rtl/core/psc_pkg.sv
// ----------------------------------------------------------------------------
// psc_pkg
// shared types and codes for the plane side classifier
// ----------------------------------------------------------------------------
package psc_pkg;

    // field widths
    localparam int NORMAL_W = 18;   // signed q1.16
    localparam int COORD_W  = 32;   // signed q16.16
    localparam int RADIUS_W = 31;   // unsigned q15.16
    localparam int PROD_W   = NORMAL_W + COORD_W;  // exact product, q17.32
    localparam int SUM_W    = PROD_W + 4;          // three products plus offset
    localparam int FRAC_W   = 16;                  // shift to reach the q.32 scale

    // query kinds
    localparam logic [1:0] ACT_POINT  = 2'd0;
    localparam logic [1:0] ACT_BOX    = 2'd1;
    localparam logic [1:0] ACT_SPHERE = 2'd2;

    // register indexes (byte address 4 * index)
    localparam logic [1:0] REG_NORMAL_X     = 2'd0;
    localparam logic [1:0] REG_NORMAL_Y     = 2'd1;
    localparam logic [1:0] REG_NORMAL_Z     = 2'd2;
    localparam logic [1:0] REG_PLANE_OFFSET = 2'd3;

    typedef enum logic [2:0] {
        SIDE_NONE   = 3'd0,
        SIDE_POS    = 3'd1,
        SIDE_NEG    = 3'd2,
        SIDE_ON     = 3'd3,
        SIDE_ACROSS = 3'd4
    } side_t;

    typedef logic signed [SUM_W-1:0] sum_t;

    // products for the least (lo) and greatest (hi) dot product;
    // lo holds n.p for point and sphere queries
    typedef struct packed {
        logic signed [PROD_W-1:0] lo_x;
        logic signed [PROD_W-1:0] lo_y;
        logic signed [PROD_W-1:0] lo_z;
        logic signed [PROD_W-1:0] hi_x;
        logic signed [PROD_W-1:0] hi_y;
        logic signed [PROD_W-1:0] hi_z;
    } span_prod_t;

endpackage

### rtl/core/psc_span.sv
// ----------------------------------------------------------------------------
// psc_span
// corner selection and normal-by-coordinate products
// ----------------------------------------------------------------------------
module psc_span (
    input  logic [1:0]                                  action,
    input  logic signed [psc_pkg::NORMAL_W-1:0]         normal_x,
    input  logic signed [psc_pkg::NORMAL_W-1:0]         normal_y,
    input  logic signed [psc_pkg::NORMAL_W-1:0]         normal_z,
    input  logic signed [psc_pkg::COORD_W-1:0]          point_x,
    input  logic signed [psc_pkg::COORD_W-1:0]          point_y,
    input  logic signed [psc_pkg::COORD_W-1:0]          point_z,
    input  logic signed [psc_pkg::COORD_W-1:0]          box_max_x,
    input  logic signed [psc_pkg::COORD_W-1:0]          box_max_y,
    input  logic signed [psc_pkg::COORD_W-1:0]          box_max_z,
    output psc_pkg::span_prod_t                         prod
);

    logic is_box;
    logic pos_x, pos_y, pos_z;
    logic signed [psc_pkg::COORD_W-1:0] lo_x, lo_y, lo_z;
    logic signed [psc_pkg::COORD_W-1:0] hi_x, hi_y, hi_z;

    assign is_box = (action == psc_pkg::ACT_BOX);

    // strictly positive component picks the minimum corner for the least value
    assign pos_x = !normal_x[psc_pkg::NORMAL_W-1] && (normal_x != '0);
    assign pos_y = !normal_y[psc_pkg::NORMAL_W-1] && (normal_y != '0);
    assign pos_z = !normal_z[psc_pkg::NORMAL_W-1] && (normal_z != '0);

    always_comb
    begin
        lo_x = point_x;
        lo_y = point_y;
        lo_z = point_z;
        hi_x = box_max_x;
        hi_y = box_max_y;
        hi_z = box_max_z;
        if (is_box)
        begin
            lo_x = pos_x ? point_x : box_max_x;
            lo_y = pos_y ? point_y : box_max_y;
            lo_z = pos_z ? point_z : box_max_z;
            hi_x = pos_x ? box_max_x : point_x;
            hi_y = pos_y ? box_max_y : point_y;
            hi_z = pos_z ? box_max_z : point_z;
        end
    end

    assign prod.lo_x = normal_x * lo_x;
    assign prod.lo_y = normal_y * lo_y;
    assign prod.lo_z = normal_z * lo_z;
    assign prod.hi_x = normal_x * hi_x;
    assign prod.hi_y = normal_y * hi_y;
    assign prod.hi_z = normal_z * hi_z;

endmodule

### rtl/core/plane_side_classifier.sv
// ----------------------------------------------------------------------------
// plane_side_classifier
// classifies a point, box or sphere against one configured plane n.p + d
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                  payload
//  -------   ---------  -------------------------  -------------------------
//  query     in         query_valid / query_stall  action, point, box, radius
//  result    out        result_valid/result_stall  side
//  config    in         apb write/read             normal_x/y/z, plane_offset
//
// three register stages: query register, product register (six 18x32
// multipliers), result register. one query per cycle unless query_stall is high;
// a query passes through the query, product and result registers in that order,
// and the multipliers set the stage boundary.
// reset clears the valid bits and the plane registers; payloads are not reset.
// each stage loads whenever it is empty or its content moves on, so a waiting
// result does not block new queries until all three stages are full.
// ----------------------------------------------------------------------------
module plane_side_classifier (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // configuration port
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [3:0]                              paddr,
    input  logic [31:0]                             pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready,
    // query channel
    input  logic                                    query_valid,
    output logic                                    query_stall,
    input  logic [1:0]                              action,
    input  logic signed [psc_pkg::COORD_W-1:0]      point_x,
    input  logic signed [psc_pkg::COORD_W-1:0]      point_y,
    input  logic signed [psc_pkg::COORD_W-1:0]      point_z,
    input  logic signed [psc_pkg::COORD_W-1:0]      box_max_x,
    input  logic signed [psc_pkg::COORD_W-1:0]      box_max_y,
    input  logic signed [psc_pkg::COORD_W-1:0]      box_max_z,
    input  logic [psc_pkg::RADIUS_W-1:0]            radius,
    input  logic                                    box_infinite,
    input  logic                                    box_null,
    // result channel
    output logic                                    result_valid,
    input  logic                                    result_stall,
    output logic [2:0]                              side
);

    // ------------------------------------------------------------------
    // plane registers
    // ------------------------------------------------------------------
    logic signed [psc_pkg::NORMAL_W-1:0] normal_x_reg;
    logic signed [psc_pkg::NORMAL_W-1:0] normal_y_reg;
    logic signed [psc_pkg::NORMAL_W-1:0] normal_z_reg;
    logic signed [psc_pkg::COORD_W-1:0]  plane_offset_reg;
    logic                                cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_x_reg     <= '0;
            normal_y_reg     <= '0;
            normal_z_reg     <= '0;
            plane_offset_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                psc_pkg::REG_NORMAL_X:     normal_x_reg     <= pwdata[psc_pkg::NORMAL_W-1:0];
                psc_pkg::REG_NORMAL_Y:     normal_y_reg     <= pwdata[psc_pkg::NORMAL_W-1:0];
                psc_pkg::REG_NORMAL_Z:     normal_z_reg     <= pwdata[psc_pkg::NORMAL_W-1:0];
                psc_pkg::REG_PLANE_OFFSET: plane_offset_reg <= pwdata;
                default:                   plane_offset_reg <= plane_offset_reg;
            endcase
        end
    end

    // read back, normals zero-extended
    always_comb
    begin
        unique case (paddr[3:2])
            psc_pkg::REG_NORMAL_X:     prdata = {14'd0, normal_x_reg};
            psc_pkg::REG_NORMAL_Y:     prdata = {14'd0, normal_y_reg};
            psc_pkg::REG_NORMAL_Z:     prdata = {14'd0, normal_z_reg};
            psc_pkg::REG_PLANE_OFFSET: prdata = plane_offset_reg;
            default:                   prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // pipeline flow control
    // ------------------------------------------------------------------
    logic q_valid_reg,  q_valid_next;
    logic p_valid_reg,  p_valid_next;
    logic r_valid_reg,  r_valid_next;
    logic r_load;       // result register may take the product stage
    logic p_load;       // product stage may take the query stage
    logic q_load;       // query stage may take a new transfer
    logic query_take;

    assign r_load      = !r_valid_reg || !result_stall;
    assign p_load      = !p_valid_reg || r_load;
    assign q_load      = !q_valid_reg || p_load;
    assign query_stall = !q_load;
    assign query_take  = query_valid && q_load;

    always_comb
    begin
        q_valid_next = q_load ? query_valid : q_valid_reg;
        p_valid_next = p_load ? q_valid_reg : p_valid_reg;
        r_valid_next = r_load ? p_valid_reg : r_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
        end
        else
        begin
            q_valid_reg <= q_valid_next;
            p_valid_reg <= p_valid_next;
            r_valid_reg <= r_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: query register
    // ------------------------------------------------------------------
    logic [1:0]                          q_action_reg;
    logic signed [psc_pkg::COORD_W-1:0]  q_point_x_reg, q_point_y_reg, q_point_z_reg;
    logic signed [psc_pkg::COORD_W-1:0]  q_max_x_reg, q_max_y_reg, q_max_z_reg;
    logic [psc_pkg::RADIUS_W-1:0]        q_radius_reg;
    logic                                q_infinite_reg, q_null_reg;

    always_ff @(posedge clk)
    begin
        if (query_take)
        begin
            q_action_reg   <= action;
            q_point_x_reg  <= point_x;
            q_point_y_reg  <= point_y;
            q_point_z_reg  <= point_z;
            q_max_x_reg    <= box_max_x;
            q_max_y_reg    <= box_max_y;
            q_max_z_reg    <= box_max_z;
            q_radius_reg   <= radius;
            q_infinite_reg <= box_infinite;
            q_null_reg     <= box_null;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: corner selection and products
    // ------------------------------------------------------------------
    psc_pkg::span_prod_t                 span_prod;
    psc_pkg::span_prod_t                 p_prod_reg;
    logic [1:0]                          p_action_reg;
    logic [psc_pkg::RADIUS_W-1:0]        p_radius_reg;
    logic                                p_infinite_reg, p_null_reg;

    psc_span u_span (
        .action    (q_action_reg),
        .normal_x  (normal_x_reg),
        .normal_y  (normal_y_reg),
        .normal_z  (normal_z_reg),
        .point_x   (q_point_x_reg),
        .point_y   (q_point_y_reg),
        .point_z   (q_point_z_reg),
        .box_max_x (q_max_x_reg),
        .box_max_y (q_max_y_reg),
        .box_max_z (q_max_z_reg),
        .prod      (span_prod)
    );

    always_ff @(posedge clk)
    begin
        if (p_load && q_valid_reg)
        begin
            p_prod_reg     <= span_prod;
            p_action_reg   <= q_action_reg;
            p_radius_reg   <= q_radius_reg;
            p_infinite_reg <= q_infinite_reg;
            p_null_reg     <= q_null_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: sums, compares and side decision
    // ------------------------------------------------------------------
    logic signed [psc_pkg::COORD_W+psc_pkg::FRAC_W-1:0] offset_wide;
    psc_pkg::sum_t  dist_lo;     // n.p + d, or least value + d for a box
    psc_pkg::sum_t  dist_hi;     // greatest value + d for a box
    psc_pkg::sum_t  radius_wide;
    logic           normal_zero;
    psc_pkg::side_t point_result;
    psc_pkg::side_t side_next;
    psc_pkg::side_t side_reg;

    // offset and radius brought to the q.32 scale of the products
    assign offset_wide = {plane_offset_reg, {psc_pkg::FRAC_W{1'b0}}};
    assign radius_wide = {{(psc_pkg::SUM_W-psc_pkg::RADIUS_W-psc_pkg::FRAC_W){1'b0}},
                          p_radius_reg, {psc_pkg::FRAC_W{1'b0}}};

    assign dist_lo = psc_pkg::sum_t'(p_prod_reg.lo_x) + psc_pkg::sum_t'(p_prod_reg.lo_y)
                   + psc_pkg::sum_t'(p_prod_reg.lo_z) + psc_pkg::sum_t'(offset_wide);
    assign dist_hi = psc_pkg::sum_t'(p_prod_reg.hi_x) + psc_pkg::sum_t'(p_prod_reg.hi_y)
                   + psc_pkg::sum_t'(p_prod_reg.hi_z) + psc_pkg::sum_t'(offset_wide);

    assign normal_zero = (normal_x_reg == '0) && (normal_y_reg == '0) && (normal_z_reg == '0);

    always_comb
    begin
        if (normal_zero)
            point_result = psc_pkg::SIDE_NONE;
        else if (dist_lo > 0)
            point_result = psc_pkg::SIDE_POS;
        else if (dist_lo < 0)
            point_result = psc_pkg::SIDE_NEG;
        else
            point_result = psc_pkg::SIDE_ON;
    end

    always_comb
    begin
        unique case (p_action_reg)
            psc_pkg::ACT_POINT:
                side_next = point_result;
            psc_pkg::ACT_BOX:
            begin
                // infinite wins over null
                if (p_infinite_reg)
                    side_next = psc_pkg::SIDE_ACROSS;
                else if (p_null_reg)
                    side_next = psc_pkg::SIDE_NONE;
                else if (dist_lo >= 0)
                    side_next = psc_pkg::SIDE_POS;
                else if (dist_hi <= 0)
                    side_next = psc_pkg::SIDE_NEG;
                else
                    side_next = psc_pkg::SIDE_ACROSS;
            end
            psc_pkg::ACT_SPHERE:
            begin
                // |dist| < radius without forming the absolute value
                if ((dist_lo < radius_wide) && (dist_lo > -radius_wide))
                    side_next = psc_pkg::SIDE_ACROSS;
                else
                    side_next = point_result;
            end
            default:
                side_next = psc_pkg::SIDE_NONE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (r_load && p_valid_reg)
            side_reg <= side_next;
    end

    assign result_valid = r_valid_reg;
    assign side         = side_reg;

endmodule

### tb/plane_side_classifier_tb.sv
// ----------------------------------------------------------------------------
// plane_side_classifier_tb
// self-checking bench for the plane side classifier: a directed table of
// point, box and sphere queries, then random queries over several planes,
// each result compared with a behavioural prediction in transfer order
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module plane_side_classifier_tb;

    // q16.16 and q1.16 unit values, coordinate extremes
    localparam int               ONE      = 32'sh0001_0000;
    localparam logic signed [17:0] N_ONE  = 18'sh1_0000;
    localparam logic signed [17:0] N_MIN  = 18'sh2_0000;
    localparam logic signed [17:0] N_MAX  = 18'sh1_FFFF;
    localparam int               C_MIN    = 32'sh8000_0000;
    localparam int               C_MAX    = 32'sh7FFF_FFFF;
    localparam logic [30:0]      R_MAX    = 31'h7FFF_FFFF;
    // query kind with no meaning, gives no side
    localparam logic [1:0]       ACT_UNUSED = 2'd3;

    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int LONG_HOLD       = 60;    // receiver hold-off, longer than the pipe
    localparam int TAIL_CYCLES     = 8;     // quiet cycles after the last result

    // how the plane of a random phase is chosen
    typedef enum int {
        PLANE_FULL,     // any normal, any offset
        PLANE_EXTREME,  // components and offset at their limits
        PLANE_UNIT,     // axis-like normals, whole-unit offsets: hits on-plane
        PLANE_FLAT      // zero normal
    } plane_style_t;

    typedef struct packed {
        logic signed [17:0] nx;
        logic signed [17:0] ny;
        logic signed [17:0] nz;
        logic signed [31:0] d;
    } plane_t;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic signed [31:0] box_max_x;
        logic signed [31:0] box_max_y;
        logic signed [31:0] box_max_z;
        logic [30:0]        radius;
        logic               box_infinite;
        logic               box_null;
    } query_t;

    // one row of the directed table; a typed side is used as it stands,
    // otherwise the side comes from the prediction
    typedef struct packed {
        plane_t         p;
        query_t         q;
        bit             typed;
        psc_pkg::side_t want;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        query_valid;
    logic        query_stall;
    logic [1:0]  action;
    logic signed [psc_pkg::COORD_W-1:0] point_x;
    logic signed [psc_pkg::COORD_W-1:0] point_y;
    logic signed [psc_pkg::COORD_W-1:0] point_z;
    logic signed [psc_pkg::COORD_W-1:0] box_max_x;
    logic signed [psc_pkg::COORD_W-1:0] box_max_y;
    logic signed [psc_pkg::COORD_W-1:0] box_max_z;
    logic [psc_pkg::RADIUS_W-1:0] radius;
    logic        box_infinite;
    logic        box_null;
    logic        result_valid;
    logic        result_stall;
    logic [2:0]  side;

    plane_side_classifier i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .query_valid  (query_valid),
        .query_stall  (query_stall),
        .action       (action),
        .point_x      (point_x),
        .point_y      (point_y),
        .point_z      (point_z),
        .box_max_x    (box_max_x),
        .box_max_y    (box_max_y),
        .box_max_z    (box_max_z),
        .radius       (radius),
        .box_infinite (box_infinite),
        .box_null     (box_null),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .side         (side)
    );

    // plane as the block holds it, mirrored once all four registers are written
    plane_t cur_plane;
    // sides still to come, oldest first
    psc_pkg::side_t sides_pending[$];
    row_t   directed_rows[$];
    int     mismatches;
    bit     calm_phase;     // no gaps on either side while set
    bit     long_hold_req;  // sender asks the receiver for one long hold-off

    // ------------------------------------------------------------------------
    // clock and run limit
    // ------------------------------------------------------------------------
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // run limit, well above the slowest correct run
    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // exact arithmetic on the q.32 scale: products of a q1.16 normal and a
    // q16.16 coordinate fit in 50 bits, so 64-bit sums never overflow
    function automatic psc_pkg::side_t classify_side(input query_t q, input plane_t p);
        longint n[3];
        longint lo[3];
        longint hi[3];
        longint offset_q32;
        longint dist_q32;
        longint dist_abs;
        longint least;
        longint most;
        bit     flat;
        psc_pkg::side_t point_result;
        n[0] = longint'($signed(p.nx));
        n[1] = longint'($signed(p.ny));
        n[2] = longint'($signed(p.nz));
        lo[0] = longint'($signed(q.point_x));
        lo[1] = longint'($signed(q.point_y));
        lo[2] = longint'($signed(q.point_z));
        hi[0] = longint'($signed(q.box_max_x));
        hi[1] = longint'($signed(q.box_max_y));
        hi[2] = longint'($signed(q.box_max_z));
        offset_q32 = longint'($signed(p.d)) * 65536;
        flat = (n[0] == 0) && (n[1] == 0) && (n[2] == 0);
        dist_q32 = n[0] * lo[0] + n[1] * lo[1] + n[2] * lo[2] + offset_q32;
        if (flat)
            point_result = psc_pkg::SIDE_NONE;
        else if (dist_q32 > 0)
            point_result = psc_pkg::SIDE_POS;
        else if (dist_q32 < 0)
            point_result = psc_pkg::SIDE_NEG;
        else
            point_result = psc_pkg::SIDE_ON;

        case (q.action)
            psc_pkg::ACT_POINT:
                return point_result;
            psc_pkg::ACT_BOX:
            begin
                // infinite beats null when both are set
                if (q.box_infinite)
                    return psc_pkg::SIDE_ACROSS;
                if (q.box_null)
                    return psc_pkg::SIDE_NONE;
                least = 0;
                most  = 0;
                // a zero component takes the max corner for the least value;
                // corners are used as given, even when min lies above max
                for (int a = 0; a < 3; a++)
                begin
                    if (n[a] > 0)
                    begin
                        least += n[a] * lo[a];
                        most  += n[a] * hi[a];
                    end
                    else
                    begin
                        least += n[a] * hi[a];
                        most  += n[a] * lo[a];
                    end
                end
                if (least >= -offset_q32)
                    return psc_pkg::SIDE_POS;
                if (most <= -offset_q32)
                    return psc_pkg::SIDE_NEG;
                return psc_pkg::SIDE_ACROSS;
            end
            psc_pkg::ACT_SPHERE:
            begin
                dist_abs = (dist_q32 < 0) ? -dist_q32 : dist_q32;
                if (dist_abs < longint'(q.radius) * 65536)
                    return psc_pkg::SIDE_ACROSS;
                return point_result;
            end
            default:
                return psc_pkg::SIDE_NONE;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // result checking: every transfer on the result side against the oldest
    // pending side
    // ------------------------------------------------------------------------
    initial mismatches = 0;

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (sides_pending.size() == 0)
            begin
                $error("side: expected nothing, got %0d", side);
                mismatches++;
            end
            else
            begin
                if (side !== sides_pending[0])
                begin
                    $error("side: expected %0d, got %0d", sides_pending[0], side);
                    mismatches++;
                end
                void'(sides_pending.pop_front());
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: random stall runs, plus one long hold-off on request so the
    // pipe fills and the query side has to stall
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 75)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    initial
    begin : receiver
        int hold_left;
        hold_left    = 0;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left == 0)
            begin
                if (long_hold_req)
                begin
                    long_hold_req = 1'b0;
                    hold_left     = LONG_HOLD;
                end
                else if (!calm_phase)
                    hold_left = pick_gap();
            end
            if (hold_left > 0)
            begin
                result_stall <= 1'b1;
                hold_left--;
            end
            else
                result_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------------

    // setup cycle, then access cycle; written at the edge with pready high
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // stop offering queries and wait for every pending side
    task automatic drain();
        @(negedge clk);
        query_valid <= 1'b0;
        while (sides_pending.size() != 0)
            @(posedge clk);
    endtask

    // registers are only touched with the block empty
    task automatic load_plane(input plane_t p);
        drain();
        write_reg(psc_pkg::REG_NORMAL_X,     {{14{p.nx[17]}}, p.nx});
        write_reg(psc_pkg::REG_NORMAL_Y,     {{14{p.ny[17]}}, p.ny});
        write_reg(psc_pkg::REG_NORMAL_Z,     {{14{p.nz[17]}}, p.nz});
        write_reg(psc_pkg::REG_PLANE_OFFSET, p.d);
        cur_plane = p;
    endtask

    // ------------------------------------------------------------------------
    // query side
    // ------------------------------------------------------------------------

    // valid is lowered once, then held low for the rest of the gap
    task automatic idle_cycles(input int n);
        if (n > 0)
        begin
            @(negedge clk);
            query_valid <= 1'b0;
            repeat (n - 1)
                @(negedge clk);
        end
    endtask

    // offer one query and hold it until the transfer; the side to expect is
    // queued at the edge of the transfer
    task automatic send_query(input query_t q, input bit typed,
                              input psc_pkg::side_t want);
        @(negedge clk);
        action       <= q.action;
        point_x      <= q.point_x;
        point_y      <= q.point_y;
        point_z      <= q.point_z;
        box_max_x    <= q.box_max_x;
        box_max_y    <= q.box_max_y;
        box_max_z    <= q.box_max_z;
        radius       <= q.radius;
        box_infinite <= q.box_infinite;
        box_null     <= q.box_null;
        query_valid  <= 1'b1;
        do
            @(posedge clk);
        while (query_stall);
        sides_pending.push_back(typed ? want : classify_side(q, cur_plane));
    endtask

    function automatic query_t mk_query(input logic [1:0] act, input int px, input int py,
                                        input int pz, input int qx, input int qy,
                                        input int qz, input int rad,
                                        input bit inf, input bit nul);
        query_t q;
        q.action       = act;
        q.point_x      = px;
        q.point_y      = py;
        q.point_z      = pz;
        q.box_max_x    = qx;
        q.box_max_y    = qy;
        q.box_max_z    = qz;
        q.radius       = 31'(rad);
        q.box_infinite = inf;
        q.box_null     = nul;
        return q;
    endfunction

    function automatic void add_row(input plane_t p, input query_t q, input bit typed,
                                    input psc_pkg::side_t want);
        row_t r;
        r.p     = p;
        r.q     = q;
        r.typed = typed;
        r.want  = want;
        directed_rows.push_back(r);
    endfunction

    // ------------------------------------------------------------------------
    // random content
    // ------------------------------------------------------------------------

    // mostly small whole or near-whole units so that sides other than the
    // obvious ones turn up, the rest over the whole range
    function automatic int pick_coord();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 4)
            return int'($urandom);
        if (roll < 8)
            return (int'($urandom_range(0, 8)) - 4) * ONE;
        return (int'($urandom_range(0, 8)) - 4) * ONE + int'($urandom_range(0, 3)) - 1;
    endfunction

    function automatic logic [30:0] pick_radius();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 3)
            return 31'($urandom);
        if (roll < 4)
            return R_MAX;
        return 31'($urandom_range(0, 6) * ONE + $urandom_range(0, 1));
    endfunction

    function automatic query_t make_random_query();
        query_t q;
        int     roll;
        roll = $urandom_range(0, 99);
        if (roll < 30)
            q.action = psc_pkg::ACT_POINT;
        else if (roll < 65)
            q.action = psc_pkg::ACT_BOX;
        else if (roll < 95)
            q.action = psc_pkg::ACT_SPHERE;
        else
            q.action = ACT_UNUSED;
        q.point_x      = pick_coord();
        q.point_y      = pick_coord();
        q.point_z      = pick_coord();
        q.box_max_x    = pick_coord();
        q.box_max_y    = pick_coord();
        q.box_max_z    = pick_coord();
        q.radius       = pick_radius();
        q.box_infinite = ($urandom_range(0, 9) == 0);
        q.box_null     = ($urandom_range(0, 9) == 0);
        return q;
    endfunction

    function automatic logic signed [17:0] pick_normal(input plane_style_t style);
        case (style)
            PLANE_FULL:
                return 18'($urandom);
            PLANE_EXTREME:
                case ($urandom_range(0, 2))
                    0:       return N_MIN;
                    1:       return N_MAX;
                    default: return '0;
                endcase
            PLANE_UNIT:
                case ($urandom_range(0, 3))
                    0:       return N_ONE;
                    1:       return -N_ONE;
                    2:       return N_ONE >>> 1;
                    default: return '0;
                endcase
            default:
                return '0;
        endcase
    endfunction

    function automatic plane_t make_plane(input plane_style_t style);
        plane_t p;
        p.nx = pick_normal(style);
        p.ny = pick_normal(style);
        p.nz = pick_normal(style);
        case (style)
            PLANE_FULL:
                p.d = $urandom;
            PLANE_EXTREME:
                p.d = $urandom_range(0, 1) ? C_MIN : C_MAX;
            default:
                p.d = (int'($urandom_range(0, 8)) - 4) * ONE;
        endcase
        return p;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    plane_t       plane_flat;
    plane_t       plane_flat_neg;
    plane_t       plane_x;
    plane_t       plane_edge_lo;
    plane_t       plane_edge_hi;
    plane_style_t phase_style[RANDOM_PHASES];

    initial
    begin
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        query_valid   = 1'b0;
        action        = psc_pkg::ACT_POINT;
        point_x       = '0;
        point_y       = '0;
        point_z       = '0;
        box_max_x     = '0;
        box_max_y     = '0;
        box_max_z     = '0;
        radius        = '0;
        box_infinite  = 1'b0;
        box_null      = 1'b0;
        calm_phase    = 1'b0;
        long_hold_req = 1'b0;
        cur_plane     = '0;     // plane registers clear on reset

        plane_flat     = '{nx: '0, ny: '0, nz: '0, d: '0};
        plane_flat_neg = '{nx: '0, ny: '0, nz: '0, d: -ONE};
        plane_x        = '{nx: N_ONE, ny: '0, nz: '0, d: '0};
        plane_edge_lo  = '{nx: N_MIN, ny: N_MAX, nz: N_MIN, d: C_MIN};
        plane_edge_hi  = '{nx: N_MAX, ny: N_MAX, nz: N_MAX, d: C_MAX};

        // zero normal straight after reset: points have no side, a box is
        // positive for d >= 0, a sphere is across only when |d| < radius
        add_row(plane_flat,
                mk_query(psc_pkg::ACT_POINT, ONE, 2 * ONE, 3 * ONE, 0, 0, 0, 0, 0, 0),
                1, psc_pkg::SIDE_NONE);
        add_row(plane_flat, mk_query(ACT_UNUSED, ONE, ONE, ONE, ONE, ONE, ONE, ONE, 1, 0),
                1, psc_pkg::SIDE_NONE);
        add_row(plane_flat, mk_query(psc_pkg::ACT_BOX, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                1, psc_pkg::SIDE_POS);
        add_row(plane_flat, mk_query(psc_pkg::ACT_BOX, 0, 0, 0, ONE, ONE, ONE, 0, 1, 1),
                1, psc_pkg::SIDE_ACROSS);
        add_row(plane_flat, mk_query(psc_pkg::ACT_BOX, 0, 0, 0, ONE, ONE, ONE, 0, 0, 1),
                1, psc_pkg::SIDE_NONE);
        add_row(plane_flat, mk_query(psc_pkg::ACT_SPHERE, 0, 0, 0, 0, 0, 0, ONE, 0, 0),
                1, psc_pkg::SIDE_ACROSS);
        add_row(plane_flat, mk_query(psc_pkg::ACT_SPHERE, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                1, psc_pkg::SIDE_NONE);
        // zero normal, negative offset
        add_row(plane_flat_neg, mk_query(psc_pkg::ACT_BOX, C_MIN, C_MIN, C_MIN,
                C_MAX, C_MAX, C_MAX, 0, 0, 0), 1, psc_pkg::SIDE_NEG);
        add_row(plane_flat_neg, mk_query(psc_pkg::ACT_SPHERE, 0, 0, 0, 0, 0, 0, ONE, 0, 0),
                1, psc_pkg::SIDE_NONE);
        add_row(plane_flat_neg,
                mk_query(psc_pkg::ACT_SPHERE, 0, 0, 0, 0, 0, 0, 2 * ONE, 0, 0),
                1, psc_pkg::SIDE_ACROSS);
        // plane x = 0
        add_row(plane_x, mk_query(psc_pkg::ACT_POINT, ONE, 0, 0, 0, 0, 0, 0, 0, 0),
                1, psc_pkg::SIDE_POS);
        add_row(plane_x, mk_query(psc_pkg::ACT_POINT, -ONE, 0, 0, 0, 0, 0, 0, 0, 0),
                1, psc_pkg::SIDE_NEG);
        add_row(plane_x, mk_query(psc_pkg::ACT_POINT, 0, C_MAX, C_MIN, 0, 0, 0, 0, 0, 0),
                1, psc_pkg::SIDE_ON);
        add_row(plane_x,
                mk_query(psc_pkg::ACT_BOX, -ONE, -ONE, -ONE, ONE, ONE, ONE, 0, 0, 0),
                0, psc_pkg::SIDE_NONE);
        // box with its minimum above its maximum
        add_row(plane_x,
                mk_query(psc_pkg::ACT_BOX, 2 * ONE, ONE, ONE, -ONE, -ONE, -ONE, 0, 0, 0),
                0, psc_pkg::SIDE_NONE);
        add_row(plane_x,
                mk_query(psc_pkg::ACT_SPHERE, 3 * ONE, 0, 0, 0, 0, 0, 2 * ONE, 0, 0),
                0, psc_pkg::SIDE_NONE);
        add_row(plane_x,
                mk_query(psc_pkg::ACT_SPHERE, -2 * ONE, 0, 0, 0, 0, 0, 2 * ONE, 0, 0),
                0, psc_pkg::SIDE_NONE);
        // extreme normals and offsets
        add_row(plane_edge_lo,
                mk_query(psc_pkg::ACT_POINT, C_MIN, C_MIN, C_MIN, 0, 0, 0, 0, 0, 0),
                0, psc_pkg::SIDE_NONE);
        add_row(plane_edge_lo,
                mk_query(psc_pkg::ACT_POINT, C_MAX, C_MAX, C_MAX, 0, 0, 0, 0, 0, 0),
                0, psc_pkg::SIDE_NONE);
        add_row(plane_edge_lo, mk_query(psc_pkg::ACT_BOX, C_MIN, C_MIN, C_MIN,
                C_MAX, C_MAX, C_MAX, 0, 0, 0), 0, psc_pkg::SIDE_NONE);
        add_row(plane_edge_lo, mk_query(psc_pkg::ACT_SPHERE, C_MAX, C_MIN, C_MAX,
                0, 0, 0, R_MAX, 0, 0), 0, psc_pkg::SIDE_NONE);
        add_row(plane_edge_hi,
                mk_query(psc_pkg::ACT_POINT, C_MIN, C_MIN, C_MIN, 0, 0, 0, 0, 0, 0),
                0, psc_pkg::SIDE_NONE);
        add_row(plane_edge_hi, mk_query(psc_pkg::ACT_BOX, C_MAX, C_MAX, C_MAX,
                C_MIN, C_MIN, C_MIN, 0, 0, 0), 0, psc_pkg::SIDE_NONE);
        add_row(plane_edge_hi,
                mk_query(psc_pkg::ACT_SPHERE, 0, 0, 0, 0, 0, 0, R_MAX, 0, 0),
                0, psc_pkg::SIDE_NONE);

        phase_style = '{PLANE_FULL, PLANE_EXTREME, PLANE_UNIT, PLANE_FLAT,
                        PLANE_FULL, PLANE_UNIT, PLANE_EXTREME, PLANE_UNIT};

        // reset held from the start, released between edges
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table; the plane is reloaded only where a row changes it
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].p != cur_plane)
                load_plane(directed_rows[i].p);
            send_query(directed_rows[i].q, directed_rows[i].typed, directed_rows[i].want);
            idle_cycles(pick_gap());
        end

        // random phases; each one drains before its plane is loaded, so the
        // sender also pauses until every side has come back
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            load_plane(make_plane(phase_style[ph]));
            calm_phase = (ph == 2) || (ph == 5);
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                // one long receiver hold-off while queries keep coming
                if (ph == 4 && k == 20)
                    long_hold_req = 1'b1;
                send_query(make_random_query(), 0, psc_pkg::SIDE_NONE);
                if (!calm_phase)
                    idle_cycles(pick_gap());
            end
        end

        calm_phase = 1'b0;
        drain();
        // catch any stray transfer after the last expected one
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
